[design/hfor_pkg.sv]
// Shared types and constants of the hover fade opacity ramp.
// Used by hfor_ctrl, hfor_dp and hover_fade_opacity_ramp; depends on nothing.
`default_nettype none

package hfor_pkg;

    // Field widths
    localparam int LEVEL_W   = 17;
    localparam int FADE_W    = 24;
    localparam int SURF_W    = 16;
    localparam int DELTA_W   = 16;
    localparam int VALUE_W   = 18;
    localparam int MODE_W    = 3;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W = 1;

    // Product of a level difference and the elapsed time, and the divider split
    localparam int PROD_W = LEVEL_W + FADE_W;
    localparam int QUOT_W = LEVEL_W;
    localparam int REM_W  = FADE_W;
    localparam int CNT_W  = 5;

    // 1.0 in opacity units
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_ID = 1'b1;

    // Item kinds; codes 6 and 7 are ignored
    typedef enum logic [MODE_W-1:0] {
        MODE_ENTER     = 3'd0,
        MODE_LEAVE     = 3'd1,
        MODE_MOVE      = 3'd2,
        MODE_TICK      = 3'd3,
        MODE_SET_BASE  = 3'd4,
        MODE_SET_HOVER = 3'd5
    } mode_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch the input transaction
        logic do_event;   // commit a hover enter or leave
        logic do_set;     // commit a set item and load the output register
        logic tick_acc;   // advance the elapsed time
        logic mul;        // load the product into the divider register
        logic div_step;   // one restoring division step
        logic tick_done;  // commit the ramp level and load the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  surf_match;
        logic  fade_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/hfor_ctrl.sv]
// Controller of the hover fade opacity ramp: sequences one transaction at a time.
// Depends on hfor_pkg; drives the command struct of hfor_dp.
`default_nettype none

module hfor_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire hfor_pkg::dp_stat_t stat,
    output hfor_pkg::dp_cmd_t      cmd
);
    import hfor_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_free;
    logic              load_out;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

    // Output slot is free if empty or drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.mode)
                    MODE_ENTER, MODE_LEAVE: begin
                        cmd.do_event = stat.surf_match;
                        state_next   = ST_IDLE;
                    end
                    MODE_TICK: begin
                        cmd.tick_acc = 1'b1;
                        state_next   = stat.fade_zero ? ST_FIN : ST_MUL;
                    end
                    MODE_SET_BASE, MODE_SET_HOVER: begin
                        if (out_free) begin
                            cmd.do_set = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.tick_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    assign load_out = cmd.do_set || cmd.tick_done;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[design/hfor_dp.sv]
// Datapath of the hover fade opacity ramp: configuration, fade state,
// multiplier, restoring divider and output register. Depends on hfor_pkg.
`default_nettype none

module hfor_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [hfor_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [hfor_pkg::MODE_W-1:0]    s_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [hfor_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hfor_pkg::FADE_W-1:0]    cfg_wdata,
    input  wire hfor_pkg::dp_cmd_t             cmd,
    output hfor_pkg::dp_stat_t                 stat,
    output logic [hfor_pkg::LEVEL_W-1:0]       opacity_out,
    output logic                               apply_now
);
    import hfor_pkg::*;

    // Configuration
    logic [FADE_W-1:0]  fade_time_reg;
    logic [SURF_W-1:0]  surface_id_reg;

    // Captured transaction
    mode_t               mode_reg;
    logic [SURF_W-1:0]   surf_reg;
    logic [DELTA_W-1:0]  delta_reg;
    logic [VALUE_W-1:0]  value_reg;

    // Fade state
    logic                hover_reg;
    logic [LEVEL_W-1:0]  base_reg, hover_lvl_reg, cur_reg, start_reg, target_reg;
    logic [FADE_W-1:0]   elapsed_reg;

    // Divider: remainder above, dividend bits shifted out and quotient in below
    logic [PROD_W-1:0]   div_reg;

    // Output register
    logic [LEVEL_W-1:0]  opacity_reg;
    logic                apply_reg;

    logic [LEVEL_W-1:0]  goal;
    logic [LEVEL_W-1:0]  clamped;
    logic                set_active;
    logic [FADE_W:0]     elapsed_sum;
    logic [FADE_W-1:0]   elapsed_next;
    logic                ramp_up;
    logic [LEVEL_W-1:0]  ramp_diff;
    logic [PROD_W-1:0]   product;
    logic [REM_W:0]      shifted;
    logic                step_ge;
    logic [REM_W:0]      step_sub;
    logic [QUOT_W-1:0]   quot;
    logic [LEVEL_W-1:0]  ramp_level;

    assign stat.mode       = mode_reg;
    assign stat.surf_match = (surf_reg == surface_id_reg);
    assign stat.fade_zero  = (fade_time_reg == '0);

    // Enter fades toward the hover level, leave toward the base level
    assign goal = (mode_reg == MODE_ENTER) ? hover_lvl_reg : base_reg;

    // Clamp the signed request to [0, 1.0]
    always_comb begin
        if (value_reg[VALUE_W-1]) begin
            clamped = '0;
        end else if (value_reg[VALUE_W-2:0] > LEVEL_ONE) begin
            clamped = LEVEL_ONE;
        end else begin
            clamped = value_reg[LEVEL_W-1:0];
        end
    end

    // Set base acts when not hovering, set hover when hovering
    assign set_active = (mode_reg == MODE_SET_BASE) ? !hover_reg : hover_reg;

    // Elapsed time: add the non-negative delta, saturate at the fade time
    always_comb begin
        elapsed_sum = {1'b0, elapsed_reg}
                    + (delta_reg[DELTA_W-1] ? '0 : (FADE_W+1)'(delta_reg));
        if (elapsed_sum > {1'b0, fade_time_reg}) begin
            elapsed_next = fade_time_reg;
        end else begin
            elapsed_next = elapsed_sum[FADE_W-1:0];
        end
    end

    // Ramp magnitude times elapsed time
    assign ramp_up   = (target_reg >= start_reg);
    assign ramp_diff = ramp_up ? (target_reg - start_reg) : (start_reg - target_reg);
    assign product   = {{FADE_W{1'b0}}, ramp_diff} * {{LEVEL_W{1'b0}}, elapsed_reg};

    // Restoring division step; the quotient fits the level width
    assign shifted  = {div_reg[PROD_W-1:QUOT_W], div_reg[QUOT_W-1]};
    assign step_ge  = (shifted >= {1'b0, fade_time_reg});
    assign step_sub = shifted - {1'b0, fade_time_reg};
    assign quot     = div_reg[QUOT_W-1:0];

    // Interpolated level, truncated toward the start level
    always_comb begin
        if (fade_time_reg == '0) begin
            ramp_level = target_reg;
        end else if (ramp_up) begin
            ramp_level = start_reg + quot;
        end else begin
            ramp_level = start_reg - quot;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_time_reg  <= '0;
            surface_id_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FADE_TIME:  fade_time_reg  <= cfg_wdata;
                CFG_SURFACE_ID: surface_id_reg <= cfg_wdata[SURF_W-1:0];
                default: ;
            endcase
        end
    end

    // Input capture, divider and output register, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= mode_t'(s_tuser);
            surf_reg  <= s_tdata[15:0];
            delta_reg <= s_tdata[31:16];
            value_reg <= s_tdata[49:32];
        end
        if (cmd.mul) begin
            div_reg <= product;
        end else if (cmd.div_step) begin
            div_reg[PROD_W-1:QUOT_W] <= step_ge ? step_sub[REM_W-1:0]
                                                 : shifted[REM_W-1:0];
            div_reg[QUOT_W-1:0]      <= {div_reg[QUOT_W-2:0], step_ge};
        end
        if (cmd.do_set) begin
            opacity_reg <= clamped;
            apply_reg   <= set_active;
        end else if (cmd.tick_done) begin
            opacity_reg <= ramp_level;
            apply_reg   <= 1'b1;
        end
    end

    // Fade state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hover_reg     <= 1'b0;
            base_reg      <= LEVEL_ONE;
            hover_lvl_reg <= LEVEL_ONE;
            cur_reg       <= LEVEL_ONE;
            start_reg     <= LEVEL_ONE;
            target_reg    <= LEVEL_ONE;
            elapsed_reg   <= '0;
        end else begin
            if (cmd.do_event) begin
                hover_reg   <= (mode_reg == MODE_ENTER);
                elapsed_reg <= '0;
                target_reg  <= goal;
                if (fade_time_reg == '0) begin
                    cur_reg   <= goal;
                    start_reg <= goal;
                end else begin
                    start_reg <= cur_reg;
                end
            end
            if (cmd.do_set) begin
                if (mode_reg == MODE_SET_BASE) begin
                    base_reg <= clamped;
                end else begin
                    hover_lvl_reg <= clamped;
                end
                if (set_active) begin
                    cur_reg     <= clamped;
                    start_reg   <= clamped;
                    target_reg  <= clamped;
                    elapsed_reg <= fade_time_reg;
                end
            end
            if (cmd.tick_acc) begin
                elapsed_reg <= elapsed_next;
            end
            if (cmd.tick_done) begin
                cur_reg <= ramp_level;
            end
        end
    end

    assign opacity_out = opacity_reg;
    assign apply_now   = apply_reg;

endmodule

`default_nettype wire

[design/hover_fade_opacity_ramp.sv]
// Top level of the hover fade opacity ramp: joins controller and datapath.
// Depends on hfor_pkg, hfor_ctrl and hfor_dp.
//
// Usage:
//   Items enter on the s_ stream (tuser = kind, tdata = surface, delta, level)
//   and results leave on the m_ stream (tdata = opacity, tuser = apply flag).
//   Hover enter, leave and move items produce no result; ticks and set items
//   produce one. Configuration goes in on cfg_valid/cfg_index/cfg_wdata, and
//   cfg_ready is always high; write only while the block is idle.
//   One transaction is in work at a time. Enter, leave and move pass through
//   decode and return to idle. A set item commits in decode once the output
//   slot is free; its result is valid in the cycle after decode. A tick runs
//   decode, a multiply state, 17 steps of the restoring divider (one quotient
//   bit each), and the final add; with a fade time of zero it skips to the add.
//   The result sits in an output register; a new item is accepted while it
//   waits, and a stalled receiver holds back only the next item that has a
//   result to deliver.
//   Reset (aresetn low, synchronous) clears the configuration to zero, sets
//   every level to fully opaque, clears hover and elapsed time, and empties
//   the output register.
`default_nettype none

module hover_fade_opacity_ramp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [15:0] event_surface, [31:16] time_delta, [49:32] level_value, [55:50] zero
    input  wire logic [hfor_pkg::IN_DATA_W-1:0] s_tdata,
    // [2:0] mode
    input  wire logic [hfor_pkg::MODE_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [16:0] opacity_out, [23:17] zero
    output logic [hfor_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [0] apply_now
    output logic                                m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hfor_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hfor_pkg::FADE_W-1:0]    cfg_wdata
);
    import hfor_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [LEVEL_W-1:0]  opacity;
    logic                apply;

    assign cfg_ready = 1'b1;

    hfor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hfor_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .opacity_out (opacity),
        .apply_now   (apply)
    );

    // Pack the result
    assign m_tdata = {{(OUT_DATA_W-LEVEL_W){1'b0}}, opacity};
    assign m_tuser = apply;

endmodule

`default_nettype wire
